>>> src/grlr_pkg.sv
// Shared types and constants of the gamma ramp resampler.
// Used by grlr_front, grlr_back and the top level; no dependencies.
`default_nettype none
package grlr_pkg;
   localparam int DEPTH_DEFAULT = 1024;
   localparam int IDX_W = 10;
   localparam int CHAN_W = 16;
   localparam int NCHAN = 3;
   localparam int WORD_W = CHAN_W * NCHAN;
   localparam int CNT_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int QDEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT = 2'd1;
   localparam logic [CNT_W-1:0] SOURCE_RESET = 11'd256;
   localparam logic [CNT_W-1:0] TARGET_RESET = 11'd256;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic op;
      logic ok;
      logic [IDX_W-1:0] idx;
      logic [WORD_W-1:0] data;
   } cmd_type;
endpackage
`default_nettype wire

>>> src/grlr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module grlr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> src/grlr_front.sv
// Front end: count registers, word classification and the command queue.
// Depends on grlr_pkg.
`default_nettype none
module grlr_front import grlr_pkg::*; #(
   parameter int RAMP_DEPTH = DEPTH_DEFAULT,
   localparam int SW = ($clog2(RAMP_DEPTH + 1) > CNT_W) ? $clog2(RAMP_DEPTH + 1) : CNT_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_wdata,
   input  wire logic                 push,
   input  wire logic                 clearing,
   input  wire logic                 opcode,
   input  wire logic [IDX_W-1:0]     entry_index,
   input  wire logic [WORD_W-1:0]    entry_data,
   output logic                      full,
   output logic                      cmd_valid,
   output cmd_type                   cmd,
   input  wire logic                 cmd_pop,
   output logic      [SW-1:0]        src_eff,
   output logic      [CNT_W-1:0]     tgt_count
);
   localparam int PW = $clog2(QDEPTH);

   logic [CNT_W-1:0] src_cnt_ff, src_cnt_in;
   logic [CNT_W-1:0] tgt_cnt_ff, tgt_cnt_in;
   cmd_type          q_ff [QDEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             accept, take;
   cmd_type          new_cmd;

   always_comb begin
      src_cnt_in = src_cnt_ff;
      tgt_cnt_in = tgt_cnt_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_COUNT: src_cnt_in = csr_wdata;
            CSR_TARGET_COUNT: tgt_cnt_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (src_cnt_ff == '0) begin
         src_eff = SW'(1);
      end else if (SW'(src_cnt_ff) > SW'(RAMP_DEPTH)) begin
         src_eff = SW'(RAMP_DEPTH);
      end else begin
         src_eff = SW'(src_cnt_ff);
      end
   end

   assign tgt_count = tgt_cnt_ff;
   assign full = (count_ff == (PW + 1)'(QDEPTH)) || clearing;
   assign accept = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign take = cmd_pop && cmd_valid;
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op = opcode;
      new_cmd.idx = entry_index;
      new_cmd.data = entry_data;
      if (opcode == OP_WRITE) begin
         new_cmd.ok = (SW'(entry_index) < src_eff);
      end else begin
         new_cmd.ok = (CNT_W'(entry_index) < tgt_cnt_ff);
      end
   end

   always_comb begin
      wr_ptr_in = accept ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cnt_ff <= SOURCE_RESET;
         tgt_cnt_ff <= TARGET_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         src_cnt_ff <= src_cnt_in;
         tgt_cnt_ff <= tgt_cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end
endmodule
`default_nettype wire

>>> src/grlr_back.sv
// Back end: ramp RAM with clearing pass, position divider, interpolation
// multipliers, rounding divider and result register. Depends on grlr_pkg, grlr_ram.
`default_nettype none
module grlr_back import grlr_pkg::*; #(
   parameter int RAMP_DEPTH = DEPTH_DEFAULT,
   localparam int SW = ($clog2(RAMP_DEPTH + 1) > CNT_W) ? $clog2(RAMP_DEPTH + 1) : CNT_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire cmd_type          cmd,
   output logic                  cmd_pop,
   input  wire logic [SW-1:0]    src_eff,
   input  wire logic [CNT_W-1:0] tgt_count,
   output logic                  clearing,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [CHAN_W-1:0]     rsp_red_out,
   output logic [CHAN_W-1:0]     rsp_green_out,
   output logic [CHAN_W-1:0]     rsp_blue_out,
   output logic [IDX_W-1:0]      rsp_out_index,
   output logic                  rsp_range_error
);
   localparam int AW = $clog2(RAMP_DEPTH);
   localparam int NW = IDX_W + SW;
   localparam int CTW = $clog2(NW);
   localparam int PW = CHAN_W + CNT_W;
   localparam int NUMW = PW + 1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIV1  = 4'd2;
   localparam logic [3:0] ST_RDA   = 4'd3;
   localparam logic [3:0] ST_RDB   = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_SUM   = 4'd6;
   localparam logic [3:0] ST_DIV2  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CTW-1:0]   cnt_ff, cnt_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] rem1_ff, rem1_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             err_ff, err_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [NCHAN-1:0][PW-1:0]     pa_ff, pa_in, pb_ff, pb_in;
   logic [NCHAN-1:0][CNT_W:0]    rem2_ff, rem2_in;
   logic [NCHAN-1:0][CHAN_W-1:0] q2_ff, q2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NCHAN-1:0][CHAN_W-1:0] rsp_chan_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_err_ff;
   logic             load_rsp;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic [CNT_W-1:0] dm1;
   logic [SW-1:0]    s_m1;
   logic [NW-1:0]    n_prod;
   logic [CNT_W:0]   t1;
   logic [CNT_W:0]   den;
   logic [CNT_W+1:0] t2;
   logic [NUMW-1:0]  num;
   logic             copy;

   grlr_ram #(.WIDTH(WORD_W), .DEPTH(RAMP_DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   assign dm1 = tgt_count - 1'b1;
   assign s_m1 = src_eff - 1'b1;
   assign n_prod = NW'(cmd.idx) * NW'(s_m1);
   assign den = {dm1, 1'b0};
   assign copy = (dm1 == '0) || (({1'b0, quo_ff} + 1'b1) >= (NW + 1)'(src_eff));
   assign clearing = (state_ff == ST_CLEAR);
   assign load_rsp = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem1_in = rem1_ff;
      idx_in = idx_ff;
      err_in = err_ff;
      a_in = a_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      rem2_in = rem2_ff;
      q2_in = q2_ff;
      cmd_pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = AW'(cmd.idx);
      ram_wdata = cmd.data;
      ram_raddr = AW'(quo_ff);
      t1 = '0;
      t2 = '0;
      num = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(RAMP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_WRITE) begin
                  ram_we = cmd.ok;
               end else begin
                  idx_in = cmd.idx;
                  err_in = !cmd.ok;
                  quo_in = n_prod;
                  rem1_in = '0;
                  cnt_in = '0;
                  if (!cmd.ok) begin
                     q2_in = '0;
                     state_in = ST_OUT;
                  end else if (dm1 == '0) begin
                     state_in = ST_RDA;
                  end else begin
                     state_in = ST_DIV1;
                  end
               end
            end
         end
         ST_DIV1: begin
            t1 = {rem1_ff, quo_ff[NW-1]};
            if (t1 >= (CNT_W + 1)'(dm1)) begin
               rem1_in = CNT_W'(t1 - (CNT_W + 1)'(dm1));
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem1_in = CNT_W'(t1);
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            cnt_in = CTW'(cnt_ff + 1'b1);
            if (cnt_ff == CTW'(NW - 1)) begin
               state_in = ST_RDA;
            end
         end
         ST_RDA: begin
            state_in = ST_RDB;
         end
         ST_RDB: begin
            a_in = ram_rdata;
            ram_raddr = AW'(quo_ff + 1'b1);
            if (copy) begin
               for (int c = 0; c < NCHAN; c++) begin
                  q2_in[c] = ram_rdata[CHAN_W*(NCHAN-1-c) +: CHAN_W];
               end
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            for (int c = 0; c < NCHAN; c++) begin
               pa_in[c] = PW'(a_ff[CHAN_W*(NCHAN-1-c) +: CHAN_W]) * PW'(dm1 - rem1_ff);
               pb_in[c] = PW'(ram_rdata[CHAN_W*(NCHAN-1-c) +: CHAN_W]) * PW'(rem1_ff);
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            for (int c = 0; c < NCHAN; c++) begin
               num = NUMW'({NUMW'(pa_ff[c]) + NUMW'(pb_ff[c]), 1'b0}) + NUMW'(dm1);
               rem2_in[c] = num[NUMW-1:CHAN_W];
               q2_in[c] = num[CHAN_W-1:0];
            end
            cnt_in = '0;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            for (int c = 0; c < NCHAN; c++) begin
               t2 = {rem2_ff[c], q2_ff[c][CHAN_W-1]};
               if (t2 >= (CNT_W + 2)'(den)) begin
                  rem2_in[c] = (CNT_W + 1)'(t2 - (CNT_W + 2)'(den));
                  q2_in[c] = {q2_ff[c][CHAN_W-2:0], 1'b1};
               end else begin
                  rem2_in[c] = (CNT_W + 1)'(t2);
                  q2_in[c] = {q2_ff[c][CHAN_W-2:0], 1'b0};
               end
            end
            cnt_in = CTW'(cnt_ff + 1'b1);
            if (cnt_ff == CTW'(CHAN_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem1_ff <= rem1_in;
      idx_ff <= idx_in;
      err_ff <= err_in;
      a_ff <= a_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      rem2_ff <= rem2_in;
      q2_ff <= q2_in;
      if (load_rsp) begin
         rsp_chan_ff <= q2_ff;
         rsp_idx_ff <= idx_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_red_out = rsp_chan_ff[0];
   assign rsp_green_out = rsp_chan_ff[1];
   assign rsp_blue_out = rsp_chan_ff[2];
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_range_error = rsp_err_ff;

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !cmd_pop))
      else $error("activity during clearing pass");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |->
      (rsp_chan_ff[0] == '0 && rsp_chan_ff[1] == '0 && rsp_chan_ff[2] == '0))
      else $error("range error word carries data");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_pop) |=> (state_ff == ST_OUT))
      else $error("result dropped while output stalled");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2) |->
      (rem2_ff[0] < den && rem2_ff[1] < den && rem2_ff[2] < den))
      else $error("rounding divider remainder out of range");
endmodule
`default_nettype wire

>>> src/gamma_ramp_linear_resampler_core.sv
// Gamma ramp linear resampler, top level.
// Depends on grlr_pkg, grlr_front, grlr_back (which holds grlr_ram).
//
// Request words: opcode 0 stores red/green/blue at entry_index in the
// source ramp (ignored when the index is not below the clamped source
// count); opcode 1 queries destination point entry_index of the ramp
// resampled onto target_count points. Each query returns one response word;
// writes return none. A word is taken when req_push is high and req_full low.
// Responses come out in order; one sits on rsp_* while rsp_empty is low and
// leaves on rsp_pop. Count registers are written on csr_we (index 0 source,
// index 1 target); the user writes them only while idle (not enforced here).
// Flow: with the back end free, a taken write is stored in the ramp RAM when
// the back end pops it from the queue; a query's result is computed with the
// bit-serial position divider and, unless an entry is copied, the 16-step
// rounding divider, then registered on rsp_*; one query at a time.
// A two-word queue sits between front and back. While the receiver stalls
// the back end keeps retiring writes until the next query is done, then
// waits on it; the queue fills and req_full rises.
// After reset the ramp RAM is cleared, one entry per cycle, over all
// RAMP_DEPTH entries; req_full stays high meanwhile and counts return to 256.
`default_nettype none
module gamma_ramp_linear_resampler_core import grlr_pkg::*; #(
   parameter int RAMP_DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_wdata,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic                 req_opcode,
   input  wire logic [IDX_W-1:0]     req_entry_index,
   input  wire logic [CHAN_W-1:0]    req_red_in,
   input  wire logic [CHAN_W-1:0]    req_green_in,
   input  wire logic [CHAN_W-1:0]    req_blue_in,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic      [CHAN_W-1:0]    rsp_red_out,
   output logic      [CHAN_W-1:0]    rsp_green_out,
   output logic      [CHAN_W-1:0]    rsp_blue_out,
   output logic      [IDX_W-1:0]     rsp_out_index,
   output logic                      rsp_range_error
);
   localparam int SW = ($clog2(RAMP_DEPTH + 1) > CNT_W) ? $clog2(RAMP_DEPTH + 1) : CNT_W;

   logic             clearing;
   logic             cmd_valid, cmd_pop;
   cmd_type          cmd;
   logic [SW-1:0]    src_eff;
   logic [CNT_W-1:0] tgt_count;

   grlr_front #(.RAMP_DEPTH(RAMP_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .push(req_push), .clearing(clearing),
      .opcode(req_opcode), .entry_index(req_entry_index),
      .entry_data({req_red_in, req_green_in, req_blue_in}),
      .full(req_full), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .src_eff(src_eff), .tgt_count(tgt_count)
   );

   grlr_back #(.RAMP_DEPTH(RAMP_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
      .src_eff(src_eff), .tgt_count(tgt_count), .clearing(clearing),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_out_index(rsp_out_index),
      .rsp_range_error(rsp_range_error)
   );
endmodule
`default_nettype wire
